>>> hdl/a2i_pkg.sv
// ----------------------------------------------------------------------------
// a2i_pkg
// Widths, latencies and pipeline types shared by the 2-D affine inverse unit.
// ----------------------------------------------------------------------------
package a2i_pkg;

   localparam int unsigned WordW  = 64;   // Q32.32 coefficient width
   localparam int unsigned ProdW  = 128;  // exact product of two coefficients
   localparam int unsigned DiffW  = 129;  // difference of two products
   localparam int unsigned NumW   = 161;  // numerator magnitude
   localparam int unsigned DenW   = 128;  // determinant magnitude
   localparam int unsigned QuoW   = 65;   // quotient with one rounding bit
   localparam int unsigned MulLat = 3;
   localparam int unsigned DivLat = QuoW + 2;
   localparam int unsigned Lat    = MulLat + 2 + DivLat;
   localparam int unsigned NumDiv = 6;

   // State of one long-division step.
   typedef struct packed {
      logic [DenW-1:0] rem;
      logic [QuoW-1:0] low;
      logic [DenW-1:0] den;
      logic [QuoW-1:0] quo;
      logic            neg;
      logic            ovf;
      logic            zero;
   } div_step_type;

   // Coefficients that the numerator stage needs after the multipliers.
   typedef struct packed {
      logic [WordW-1:0] b;
      logic [WordW-1:0] c;
      logic [WordW-1:0] e;
      logic [WordW-1:0] f;
   } coef_type;

endpackage

>>> hdl/a2i_mult.sv
// ----------------------------------------------------------------------------
// a2i_mult
// Exact signed 64x64 product, built from four 33x33 partial products over
// three register stages.
// ----------------------------------------------------------------------------
module a2i_mult (
   input  logic                            clock,
   input  logic                            en,
   input  logic [a2i_pkg::WordW-1:0]       a,
   input  logic [a2i_pkg::WordW-1:0]       b,
   output logic [a2i_pkg::ProdW-1:0]       prod
);

   logic signed [32:0] ah, al, bh, bl;
   logic signed [65:0] hh_ff, hl_ff, lh_ff, ll_ff;
   logic signed [65:0] hh_in, hl_in, lh_in, ll_in;
   logic signed [65:0] hh2_ff, ll2_ff;
   logic signed [66:0] cross_ff, cross_in;
   logic [127:0]       hh_ext, cross_ext, ll_ext, prod_in, prod_ff;

   // Upper halves carry the sign; lower halves are unsigned.
   assign ah = {a[63], a[63:32]};
   assign al = {1'b0, a[31:0]};
   assign bh = {b[63], b[63:32]};
   assign bl = {1'b0, b[31:0]};

   assign hh_in = ah * bh;
   assign hl_in = ah * bl;
   assign lh_in = al * bh;
   assign ll_in = al * bl;

   assign cross_in = {hl_ff[65], hl_ff} + {lh_ff[65], lh_ff};

   assign hh_ext    = {{62{hh2_ff[65]}}, hh2_ff};
   assign cross_ext = {{61{cross_ff[66]}}, cross_ff};
   assign ll_ext    = {64'd0, ll2_ff[63:0]};
   assign prod_in   = (hh_ext << 64) + (cross_ext << 32) + ll_ext;

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff    <= hh_in;
         hl_ff    <= hl_in;
         lh_ff    <= lh_in;
         ll_ff    <= ll_in;
         hh2_ff   <= hh_ff;
         ll2_ff   <= ll_ff;
         cross_ff <= cross_in;
         prod_ff  <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

>>> hdl/a2i_div_step.sv
// ----------------------------------------------------------------------------
// a2i_div_step
// One registered step of restoring division: one quotient bit per stage.
// ----------------------------------------------------------------------------
module a2i_div_step (
   input  logic                        clock,
   input  logic                        en,
   input  a2i_pkg::div_step_type       step_i,
   output a2i_pkg::div_step_type       step_o
);

   logic [a2i_pkg::DenW:0] part, diff;
   logic                   ge;
   a2i_pkg::div_step_type  step_in, step_ff;

   always_comb begin
      part    = {step_i.rem, step_i.low[a2i_pkg::QuoW-1]};
      diff    = part - {1'b0, step_i.den};
      ge      = part >= {1'b0, step_i.den};
      step_in = step_i;
      step_in.rem = ge ? diff[a2i_pkg::DenW-1:0] : part[a2i_pkg::DenW-1:0];
      step_in.low = {step_i.low[a2i_pkg::QuoW-2:0], 1'b0};
      step_in.quo = {step_i.quo[a2i_pkg::QuoW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign step_o = step_ff;

endmodule

>>> hdl/a2i_divider.sv
// ----------------------------------------------------------------------------
// a2i_divider
// Pipelined signed divide of a numerator magnitude by the determinant
// magnitude, rounded to nearest with ties away from zero and saturated.
// ----------------------------------------------------------------------------
module a2i_divider (
   input  logic                          clock,
   input  logic                          en,
   input  logic [a2i_pkg::NumW-1:0]      num_mag,
   input  logic [a2i_pkg::DenW-1:0]      den_mag,
   input  logic                          neg,
   input  logic                          zero,
   output logic [a2i_pkg::WordW-1:0]     quo,
   output logic                          zero_out
);

   localparam logic [64:0] PosLimit = {2'b00, {63{1'b1}}};
   localparam logic [64:0] NegLimit = {2'b01, 63'd0};

   a2i_pkg::div_step_type pipe_w [0:a2i_pkg::QuoW];
   a2i_pkg::div_step_type first_in, first_ff;
   logic [65:0]  rsum;
   logic [64:0]  rnd;
   logic [63:0]  quo_in, quo_ff;
   logic         zero_ff;

   // The quotient is at least 2^64 exactly when the numerator reaches the
   // divisor shifted up by 64; then only the sign matters.
   always_comb begin
      first_in.rem  = {31'd0, num_mag[160:64]};
      first_in.low  = {num_mag[63:0], 1'b0};
      first_in.den  = den_mag;
      first_in.quo  = '0;
      first_in.neg  = neg;
      first_in.zero = zero;
      first_in.ovf  = {31'd0, num_mag} >= {den_mag, 64'd0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         first_ff <= first_in;
      end
   end

   assign pipe_w[0] = first_ff;

   for (genvar k = 0; k < a2i_pkg::QuoW; k++) begin : g_step
      a2i_div_step u_step (
         .clock  (clock),
         .en     (en),
         .step_i (pipe_w[k]),
         .step_o (pipe_w[k+1])
      );
   end

   // The last quotient bit is the half bit: adding one and dropping it rounds.
   always_comb begin
      rsum = {1'b0, pipe_w[a2i_pkg::QuoW].quo} + 66'd1;
      rnd  = rsum[65:1];
      if (pipe_w[a2i_pkg::QuoW].zero) begin
         quo_in = '0;
      end else if (pipe_w[a2i_pkg::QuoW].neg) begin
         if (pipe_w[a2i_pkg::QuoW].ovf || rnd > NegLimit) begin
            quo_in = {1'b1, 63'd0};
         end else begin
            quo_in = 64'd0 - rnd[63:0];
         end
      end else begin
         if (pipe_w[a2i_pkg::QuoW].ovf || rnd > PosLimit) begin
            quo_in = {1'b0, {63{1'b1}}};
         end else begin
            quo_in = rnd[63:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff  <= quo_in;
         zero_ff <= pipe_w[a2i_pkg::QuoW].zero;
      end
   end

   assign quo      = quo_ff;
   assign zero_out = zero_ff;

endmodule

>>> hdl/affine_2d_inverse_unit.sv
// ----------------------------------------------------------------------------
// affine_2d_inverse_unit
// Inverts a 2-D affine map given in signed Q32.32 coefficients.
// ----------------------------------------------------------------------------
// Usage: an item on the req_ channel carries the six forward coefficients
// X = A + B*S + C*L, Y = D + E*S + F*L. The rsp_ channel returns the six
// inverse coefficients for S and L, each rounded to nearest (ties away from
// zero) and saturated, plus rsp_solvable, which is low when the determinant
// B*F - C*E is zero; the coefficients are then all zero.
// From acceptance to rsp_valid an item passes three multiplier stages, a
// determinant stage, a magnitude stage, and six parallel dividers of 67
// stages each: an input stage, one per quotient bit, and an output stage.
// Throughput is one item per cycle unless the output stalls; the divider stages set the depth.
// Reset clears the valid bits of every stage, so no result is shown until
// a new item has gone through. When the receiver holds rsp_ready low while a
// result waits, the whole pipeline holds and req_ready drops; bubbles in
// the pipeline are not squeezed out.
// ----------------------------------------------------------------------------
module affine_2d_inverse_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_x_const,
   input  logic [63:0] req_x_per_sample,
   input  logic [63:0] req_x_per_line,
   input  logic [63:0] req_y_const,
   input  logic [63:0] req_y_per_sample,
   input  logic [63:0] req_y_per_line,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_s_const,
   output logic [63:0] rsp_s_per_x,
   output logic [63:0] rsp_s_per_y,
   output logic [63:0] rsp_l_const,
   output logic [63:0] rsp_l_per_x,
   output logic [63:0] rsp_l_per_y,
   output logic        rsp_solvable
);

   function automatic logic [63:0] mag64(input logic [63:0] v);
      mag64 = v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [127:0] mag129(input logic [128:0] v);
      logic [128:0] n;
      n = 129'd0 - v;
      mag129 = v[128] ? n[127:0] : v[127:0];
   endfunction

   logic                         adv;
   logic [a2i_pkg::Lat-1:0]      vld_ff, vld_in;

   logic [a2i_pkg::ProdW-1:0]    p_bf, p_ce, p_cd, p_fa, p_ea, p_bd;
   a2i_pkg::coef_type            dly_ff [0:a2i_pkg::MulLat];
   a2i_pkg::coef_type            coef_in;

   logic [a2i_pkg::DiffW-1:0]    det_ff, ns_ff, nl_ff;
   logic [a2i_pkg::DiffW-1:0]    det_in, ns_in, nl_in;

   logic [a2i_pkg::NumW-1:0]     num_in [0:a2i_pkg::NumDiv-1];
   logic [a2i_pkg::NumW-1:0]     num_ff [0:a2i_pkg::NumDiv-1];
   logic                         neg_in [0:a2i_pkg::NumDiv-1];
   logic                         neg_ff [0:a2i_pkg::NumDiv-1];
   logic [a2i_pkg::DenW-1:0]     den_ff, den_in;
   logic                         zero_ff, zero_in;
   logic                         ds;

   logic [63:0]                  quo_w [0:a2i_pkg::NumDiv-1];
   logic                         zero_w [0:a2i_pkg::NumDiv-1];

   // A single enable moves every stage; the last stage only moves on when
   // its result is gone or is being taken.
   assign adv       = !vld_ff[a2i_pkg::Lat-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[a2i_pkg::Lat-1];
   assign vld_in    = {vld_ff[a2i_pkg::Lat-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   a2i_mult u_bf (.clock(clock), .en(adv), .a(req_x_per_sample),
                  .b(req_y_per_line), .prod(p_bf));
   a2i_mult u_ce (.clock(clock), .en(adv), .a(req_x_per_line),
                  .b(req_y_per_sample), .prod(p_ce));
   a2i_mult u_cd (.clock(clock), .en(adv), .a(req_x_per_line),
                  .b(req_y_const), .prod(p_cd));
   a2i_mult u_fa (.clock(clock), .en(adv), .a(req_y_per_line),
                  .b(req_x_const), .prod(p_fa));
   a2i_mult u_ea (.clock(clock), .en(adv), .a(req_y_per_sample),
                  .b(req_x_const), .prod(p_ea));
   a2i_mult u_bd (.clock(clock), .en(adv), .a(req_x_per_sample),
                  .b(req_y_const), .prod(p_bd));

   // The plain coefficients ride alongside the multipliers.
   assign coef_in = '{b: req_x_per_sample, c: req_x_per_line,
                      e: req_y_per_sample, f: req_y_per_line};

   always_ff @(posedge clock) begin
      if (adv) begin
         dly_ff[0] <= coef_in;
         for (int i = 1; i <= a2i_pkg::MulLat; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   // Determinant and the two constant-term numerators, exact in 129 bits.
   assign det_in = {p_bf[127], p_bf} - {p_ce[127], p_ce};
   assign ns_in  = {p_cd[127], p_cd} - {p_fa[127], p_fa};
   assign nl_in  = {p_ea[127], p_ea} - {p_bd[127], p_bd};

   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff <= det_in;
         ns_ff  <= ns_in;
         nl_ff  <= nl_in;
      end
   end

   // Numerator magnitudes and quotient signs. The constant terms carry a
   // 32-bit shift, the linear terms a 64-bit shift, to land in Q32.32.
   always_comb begin
      ds        = det_ff[128];
      den_in    = mag129(det_ff);
      zero_in   = det_ff == '0;
      num_in[0] = {1'b0, mag129(ns_ff), 32'd0};
      num_in[1] = {33'd0, mag64(dly_ff[a2i_pkg::MulLat].f), 64'd0};
      num_in[2] = {33'd0, mag64(dly_ff[a2i_pkg::MulLat].c), 64'd0};
      num_in[3] = {1'b0, mag129(nl_ff), 32'd0};
      num_in[4] = {33'd0, mag64(dly_ff[a2i_pkg::MulLat].e), 64'd0};
      num_in[5] = {33'd0, mag64(dly_ff[a2i_pkg::MulLat].b), 64'd0};
      neg_in[0] = ns_ff[128] ^ ds;
      neg_in[1] = dly_ff[a2i_pkg::MulLat].f[63] ^ ds;
      neg_in[2] = !dly_ff[a2i_pkg::MulLat].c[63] ^ ds;
      neg_in[3] = nl_ff[128] ^ ds;
      neg_in[4] = !dly_ff[a2i_pkg::MulLat].e[63] ^ ds;
      neg_in[5] = dly_ff[a2i_pkg::MulLat].b[63] ^ ds;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff  <= den_in;
         zero_ff <= zero_in;
         for (int i = 0; i < a2i_pkg::NumDiv; i++) begin
            num_ff[i] <= num_in[i];
            neg_ff[i] <= neg_in[i];
         end
      end
   end

   for (genvar j = 0; j < a2i_pkg::NumDiv; j++) begin : g_div
      a2i_divider u_div (
         .clock    (clock),
         .en       (adv),
         .num_mag  (num_ff[j]),
         .den_mag  (den_ff),
         .neg      (neg_ff[j]),
         .zero     (zero_ff),
         .quo      (quo_w[j]),
         .zero_out (zero_w[j])
      );
   end

   assign rsp_s_const  = quo_w[0];
   assign rsp_s_per_x  = quo_w[1];
   assign rsp_s_per_y  = quo_w[2];
   assign rsp_l_const  = quo_w[3];
   assign rsp_l_per_x  = quo_w[4];
   assign rsp_l_per_y  = quo_w[5];
   assign rsp_solvable = !zero_w[0];

   // A singular map yields an all-zero result.
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_solvable |-> rsp_s_const == '0 && rsp_s_per_x == '0 &&
      rsp_s_per_y == '0 && rsp_l_const == '0 && rsp_l_per_x == '0 &&
      rsp_l_per_y == '0)
      else $error("singular result has nonzero coefficients");

   // All dividers see the same determinant, so they agree on singularity.
   a_zero_agree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> zero_w[0] == zero_w[5] && zero_w[1] == zero_w[4])
      else $error("dividers disagree on singular determinant");

   // A stalled output freezes every stage's valid bit.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> vld_ff == $past(vld_ff))
      else $error("pipeline moved during a stall");

   // A stalled output blocks new input.
   a_stall_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted during a stall");

endmodule

>>> dv/tb_affine_2d_inverse_unit.sv
// ----------------------------------------------------------------------------
// tb_affine_2d_inverse_unit
// Self-checking bench for the 2-D affine inverse unit. Directed corner maps
// (zero determinant, tiny determinants, field extremes) are followed by
// random maps that mix small well-conditioned and full-range coefficients.
// An exact wide-integer predictor computes every expected inverse.
// ----------------------------------------------------------------------------
module tb_affine_2d_inverse_unit;

   typedef struct {
      logic [63:0] a, b, c, d, e, f;
   } fwd_map_type;

   typedef struct {
      logic [63:0] sc, sx, sy, lc, lx, ly;
      logic        ok;
   } inv_map_type;

   localparam int NumRandom    = 1200;
   localparam int StallLimit   = 20000;
   localparam int HoldCycles   = 300;
   localparam int CalmAfter    = 1000;   // no idling after this many items sent

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_x_const, req_x_per_sample, req_x_per_line;
   logic [63:0] req_y_const, req_y_per_sample, req_y_per_line;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_s_const, rsp_s_per_x, rsp_s_per_y;
   logic [63:0] rsp_l_const, rsp_l_per_x, rsp_l_per_y;
   logic        rsp_solvable;

   fwd_map_type pending_maps[$];
   inv_map_type expected_inverses[$];
   int       errors;
   int       sent_count;
   int       checked_count;
   int       singular_count;
   int       idle_cycles;
   int       send_gap;
   int       recv_gap;
   int       hold_left;
   bit       hold_done;
   bit       stim_done;

   affine_2d_inverse_unit uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Rounded, saturated quotient n/d with d nonzero, both exact integers.
   function automatic logic [63:0] div_round_sat(logic signed [199:0] n,
                                                  logic signed [199:0] d);
      logic signed [199:0] mn, md, q, r;
      bit                  neg;
      neg = (n < 0) != (d < 0);
      mn  = (n < 0) ? -n : n;
      md  = (d < 0) ? -d : d;
      q   = mn / md;
      r   = mn % md;
      if (2 * r >= md) q = q + 1;
      if (!neg) begin
         if (q > 200'sh7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
         return q[63:0];
      end
      if (q > 200'sh8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
      return -q[63:0];
   endfunction

   function automatic inv_map_type invert_map(fwd_map_type m);
      logic signed [199:0] a, b, c, d, e, f, det;
      inv_map_type         r;
      a = $signed(m.a); b = $signed(m.b); c = $signed(m.c);
      d = $signed(m.d); e = $signed(m.e); f = $signed(m.f);
      det = b * f - c * e;
      r = '{default: '0};
      if (det == 0) return r;
      // Numerators carry the extra Q32 scale so the quotients come out in Q32.32.
      r.sc = div_round_sat((c * d - f * a) <<< 32, det);
      r.sx = div_round_sat(f <<< 64, det);
      r.sy = div_round_sat(-(c <<< 64), det);
      r.lc = div_round_sat((e * a - b * d) <<< 32, det);
      r.lx = div_round_sat(-(e <<< 64), det);
      r.ly = div_round_sat(b <<< 64, det);
      r.ok = 1'b1;
      return r;
   endfunction

   // Mostly moderate Q32.32 values, sometimes full range or an extreme.
   function automatic logic [63:0] rand_coef();
      case ($urandom_range(0, 9))
         0:       return {$urandom, $urandom};
         1:       return $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF
                                              : 64'h8000_0000_0000_0000;
         2:       return 64'($signed($urandom_range(0, 8) - 4)) <<< 32;
         3:       return 64'($signed(32'($urandom)));
         default: return {{16{1'b0}}, 48'({$urandom, $urandom})}
                         ^ ($urandom_range(0, 1) ? 64'hFFFF_0000_0000_0000 : 64'h0);
      endcase
   endfunction

   task automatic add_map(logic [63:0] a, b, c, d, e, f);
      pending_maps.push_back('{a: a, b: b, c: c, d: d, e: e, f: f});
   endtask

   initial begin
      logic [63:0] mx, mn, one;
      fwd_map_type m;
      mx  = 64'h7FFF_FFFF_FFFF_FFFF;
      mn  = 64'h8000_0000_0000_0000;
      one = 64'h1_0000_0000;
      // Identity map, then a scaled and shifted one.
      add_map(0, one, 0, 0, 0, one);
      add_map(5 * one, 2 * one, 0, -(3 * one), 0, 4 * one);
      // Zero determinant: all zero, and proportional rows.
      add_map(0, 0, 0, 0, 0, 0);
      add_map(mx, one, 2 * one, mn, 2 * one, 4 * one);
      add_map(mn, mx, mx, mx, mx, mx);
      // Tiny determinant makes the quotients saturate both ways.
      add_map(mx, 1, 0, mn, 0, 1);
      add_map(mn, 1, 0, mx, 0, -64'sd1);
      add_map(mx, -64'sd1, 1, 1, 1, 0);
      // Field extremes everywhere.
      add_map(mx, mx, mn, mn, mx, mn);
      add_map(mn, mn, mn, mn, mn, mx);
      add_map(mx, mn, mx, mx, mn, mn);
      add_map(-64'sd1, -64'sd1, 0, -64'sd1, 0, -64'sd1);
      add_map('0, mx, 0, '0, 0, mx);
      // Swapped axes (B = F = 0), then a saturating map and one whose quotient must round.
      add_map(one, 0, one, one, one, 0);
      add_map(0, 2, 0, 1, 0, 2);
      add_map(0, 3 * one, 0, 0, 0, one);
      for (int i = 0; i < NumRandom; i++) begin
         m = '{a: rand_coef(), b: rand_coef(), c: rand_coef(),
               d: rand_coef(), e: rand_coef(), f: rand_coef()};
         // Force some singular maps by making the rows proportional.
         if ($urandom_range(0, 15) == 0) begin
            m.e = m.b; m.f = m.c;
         end
         pending_maps.push_back(m);
      end
   end

   // Sender: random gaps in bursts; none in the last part of the run.
   always @(posedge clock) begin
      if (reset) begin
         req_valid        <= 1'b0;
         send_gap         <= 0;
         sent_count       <= 0;
         req_x_const      <= '0;
         req_x_per_sample <= '0;
         req_x_per_line   <= '0;
         req_y_const      <= '0;
         req_y_per_sample <= '0;
         req_y_per_line   <= '0;
      end else begin
         if (req_valid && req_ready) sent_count <= sent_count + 1;
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (sent_count < CalmAfter && $urandom_range(0, 9) == 0) begin
               send_gap  <= $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else if (pending_maps.size() > 0) begin
               fwd_map_type m;
               m = pending_maps.pop_front();
               req_x_const      <= m.a;
               req_x_per_sample <= m.b;
               req_x_per_line   <= m.c;
               req_y_const      <= m.d;
               req_y_per_sample <= m.e;
               req_y_per_line   <= m.f;
               req_valid        <= 1'b1;
               expected_inverses.push_back(invert_map(m));
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, and once a long hold so the pipeline backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else if (!hold_done && sent_count >= 200) begin
         hold_done <= 1'b1;
         hold_left <= HoldCycles;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap  <= recv_gap - 1;
         rsp_ready <= (recv_gap == 1);
      end else if (sent_count < CalmAfter && $urandom_range(0, 7) == 0) begin
         recv_gap  <= $urandom_range(1, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: compare each accepted result with the oldest expected inverse.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_inverses.size() == 0) begin
            $error("result with no expected inverse waiting");
            errors++;
         end else begin
            inv_map_type x;
            x = expected_inverses.pop_front();
            checked_count++;
            if (!x.ok) singular_count++;
            if (rsp_s_const !== x.sc) begin
               $error("s_const exp %h got %h", x.sc, rsp_s_const); errors++;
            end
            if (rsp_s_per_x !== x.sx) begin
               $error("s_per_x exp %h got %h", x.sx, rsp_s_per_x); errors++;
            end
            if (rsp_s_per_y !== x.sy) begin
               $error("s_per_y exp %h got %h", x.sy, rsp_s_per_y); errors++;
            end
            if (rsp_l_const !== x.lc) begin
               $error("l_const exp %h got %h", x.lc, rsp_l_const); errors++;
            end
            if (rsp_l_per_x !== x.lx) begin
               $error("l_per_x exp %h got %h", x.lx, rsp_l_per_x); errors++;
            end
            if (rsp_l_per_y !== x.ly) begin
               $error("l_per_y exp %h got %h", x.ly, rsp_l_per_y); errors++;
            end
            if (rsp_solvable !== x.ok) begin
               $error("solvable exp %b got %b", x.ok, rsp_solvable); errors++;
            end
         end
      end
   end

   // Watchdog: cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      stim_done     = 1'b0;
      reset         = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            wait (pending_maps.size() == 0 && !req_valid && sent_count > 0);
            wait (expected_inverses.size() == 0);
            repeat (a2i_pkg::Lat + 10) @(posedge clock);
            stim_done = 1'b1;
         end
         begin
            wait (idle_cycles >= StallLimit);
         end
      join_any
      if (!stim_done) begin
         $display("timeout with %0d results outstanding", expected_inverses.size());
         $display("FAIL affine_2d_inverse_unit");
      end else begin
         $display("Checked %0d inverse maps, %0d of them singular, including a long",
                  checked_count, singular_count);
         $display("output hold and saturating, extreme and random coefficients.");
         if (errors == 0 && expected_inverses.size() == 0)
            $display("PASS affine_2d_inverse_unit");
         else
            $display("FAIL affine_2d_inverse_unit");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/a2i_pkg.sv
hdl/a2i_mult.sv
hdl/a2i_div_step.sv
hdl/a2i_divider.sv
hdl/affine_2d_inverse_unit.sv
dv/tb_affine_2d_inverse_unit.sv
